/* hdl/bsc_pkg.sv */
`default_nettype none
package bsc_pkg;

  localparam int DIV_BITS = 64;
  localparam int FRONT_STAGES = 10;

  // configuration register indexes
  localparam logic [1:0] REG_TEMP_TRIM  = 2'd0;
  localparam logic [1:0] REG_PRESS_LOW  = 2'd1;
  localparam logic [1:0] REG_PRESS_MID  = 2'd2;
  localparam logic [1:0] REG_PRESS_HIGH = 2'd3;

  localparam logic signed [32:0] T_OFFSET  = 33'sd128000;
  localparam logic [20:0]        P_FULL    = 21'd1048576;
  localparam logic signed [12:0] P_SCALE   = 13'sd3125;
  localparam logic signed [63:0] P_BIAS    = 64'sh0000_8000_0000_0000;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } trim_t;

  // state handed along the divider chain
  typedef struct packed {
    logic               invalid;
    logic               neg;
    logic signed [31:0] temp;
    logic        [63:0] rem;
    logic        [63:0] num;
    logic        [63:0] den;
  } div_t;

  typedef struct packed {
    logic               invalid;
    logic signed [31:0] temp;
    logic        [31:0] press;
  } res_t;

endpackage
`default_nettype wire

/* hdl/bsc_if.sv */
`default_nettype none
interface bsc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic        [31:0] pressure_q24_8;
  logic               pressure_invalid;
  modport source (output valid, output temperature_centi, output pressure_q24_8,
                  output pressure_invalid, input ready);
  modport sink (input valid, input temperature_centi, input pressure_q24_8,
                input pressure_invalid, output ready);
endinterface
`default_nettype wire

/* hdl/bsc_front.sv */
`default_nettype none
module bsc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [19:0]   raw_t,
  input  wire logic [19:0]   raw_p,
  input  wire bsc_pkg::trim_t trim,
  output logic               out_valid,
  output bsc_pkg::div_t      out_data
);
  import bsc_pkg::*;

  logic [FRONT_STAGES-1:0] v;

  logic signed [17:0] s1_d1;
  logic signed [16:0] s1_d2;
  logic        [19:0] s1_p, s2_p, s3_p, s4_p, s5_p, s6_p, s7_p;
  logic signed [31:0] s2_m1, s3_x, s4_tf;
  logic        [31:0] s2_sq;
  logic signed [20:0] s3_v1;
  logic signed [31:0] s5_temp, s6_temp, s7_temp, s8_temp, s9_temp;
  logic signed [32:0] s5_a;
  logic signed [63:0] s6_aa, s7_b, s7_t, s8_a2, s8_nb, s9_m, s9_n;
  logic signed [48:0] s6_ap5, s6_ap2, s7_ap2;

  logic signed [33:0] m1_w, sq_w;
  logic signed [19:0] sq_sh;
  logic signed [35:0] x_w;
  logic signed [17:0] x_sh;
  logic signed [31:0] t5;
  logic signed [65:0] aa_w;
  logic signed [48:0] ap5_w, ap2_w;
  logic signed [79:0] aap6_w, aap3_w;
  logic        [20:0] pd;
  logic signed [63:0] a2b;
  logic signed [16:0] p1s;
  logic signed [80:0] m_w;
  logic signed [76:0] n_w;
  logic signed [63:0] adiv;
  logic               zero;

  always_comb begin
    m1_w   = s1_d1 * trim.t2;
    sq_w   = s1_d2 * s1_d2;
    sq_sh  = s2_sq[31:12];
    x_w    = sq_sh * trim.t3;
    x_sh   = s3_x[31:14];
    t5     = (s4_tf <<< 2) + s4_tf + 32'sd128;
    aa_w   = s5_a * s5_a;
    ap5_w  = s5_a * trim.p5;
    ap2_w  = s5_a * trim.p2;
    aap6_w = s6_aa * trim.p6;
    aap3_w = s6_aa * trim.p3;
    pd     = P_FULL - {1'b0, s7_p};
    a2b    = s8_a2 + P_BIAS;
    p1s    = {1'b0, trim.p1};
    m_w    = a2b * p1s;
    n_w    = s8_nb * P_SCALE;
    adiv   = s9_m >>> 33;
    zero   = (adiv == 64'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[FRONT_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d1 <= $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, trim.t1, 1'b0});
      s1_d2 <= $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, trim.t1});
      s1_p  <= raw_p;

      s2_m1 <= m1_w[31:0];
      s2_sq <= sq_w[31:0];
      s2_p  <= s1_p;

      s3_v1 <= s2_m1[31:11];
      s3_x  <= x_w[31:0];
      s3_p  <= s2_p;

      s4_tf <= 32'(s3_v1) + 32'(x_sh);
      s4_p  <= s3_p;

      s5_temp <= t5 >>> 8;
      s5_a    <= 33'(s4_tf) - T_OFFSET;
      s5_p    <= s4_p;

      s6_aa   <= aa_w[63:0];
      s6_ap5  <= ap5_w;
      s6_ap2  <= ap2_w;
      s6_temp <= s5_temp;
      s6_p    <= s5_p;

      s7_b    <= aap6_w[63:0] + (64'(s6_ap5) <<< 17) + (64'(trim.p4) <<< 35);
      s7_t    <= aap3_w[63:0];
      s7_ap2  <= s6_ap2;
      s7_temp <= s6_temp;
      s7_p    <= s6_p;

      s8_a2   <= (s7_t >>> 8) + (64'(s7_ap2) <<< 12);
      s8_nb   <= $signed(64'(pd) << 31) - s7_b;
      s8_temp <= s7_temp;

      s9_m    <= m_w[63:0];
      s9_n    <= n_w[63:0];
      s9_temp <= s8_temp;

      // magnitudes for the divider, signs settled after it
      out_data.invalid <= zero;
      out_data.neg     <= adiv[63] ^ s9_n[63];
      out_data.temp    <= s9_temp;
      out_data.rem     <= '0;
      out_data.num     <= s9_n[63] ? 64'(-s9_n) : 64'(s9_n);
      out_data.den     <= zero ? 64'd1 : (adiv[63] ? 64'(-adiv) : 64'(adiv));
    end
  end

  assign out_valid = v[FRONT_STAGES-1];

endmodule
`default_nettype wire

/* hdl/bsc_div_cell.sv */
`default_nettype none
module bsc_div_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire bsc_pkg::div_t in_data,
  output logic               out_valid,
  output bsc_pkg::div_t      out_data
);
  import bsc_pkg::*;

  logic [64:0] r;
  logic [64:0] diff;
  logic        ge;
  div_t        nxt;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    r    = {in_data.rem, in_data.num[63]};
    diff = r - {1'b0, in_data.den};
    ge   = ~diff[64];
    nxt      = in_data;
    nxt.rem  = ge ? diff[63:0] : r[63:0];
    nxt.num  = {in_data.num[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/bsc_back.sv */
`default_nettype none
module bsc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire bsc_pkg::div_t in_data,
  input  wire bsc_pkg::trim_t trim,
  output logic               out_valid,
  output bsc_pkg::res_t      out_data
);
  import bsc_pkg::*;

  logic [3:0] v;
  logic [3:0] inv;
  logic signed [31:0] temp1, temp2, temp3, temp4;
  logic signed [63:0] b1_p, b2_p, b3_p, b4_p;
  logic        [63:0] b2_ll;
  logic        [31:0] b2_hl;
  logic signed [63:0] b2_pp8, b3_qq, b3_c2, b4_c1, b4_c2;

  logic signed [63:0] q;
  logic        [63:0] ll_w;
  logic        [31:0] hl_w;
  logic signed [79:0] pp8_w, pq_w;
  logic signed [63:0] pq_lo;
  logic        [63:0] sum;
  logic        [31:0] press;

  always_comb begin
    q     = b1_p >>> 13;
    ll_w  = 64'(q[31:0]) * 64'(q[31:0]);
    hl_w  = q[63:32] * q[31:0];
    pp8_w = b1_p * trim.p8;
    pq_w  = trim.p9 * b3_qq;
    pq_lo = pq_w[63:0];
    sum   = 64'(b4_p + b4_c1 + b4_c2);
    press = sum[39:8] + {{12{trim.p7[15]}}, trim.p7, 4'b0000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv   <= {inv[2:0], in_data.invalid};
      b1_p  <= in_data.neg ? $signed(-in_data.num) : $signed(in_data.num);
      temp1 <= in_data.temp;

      // low half of q*q from two 32-bit products
      b2_ll  <= ll_w;
      b2_hl  <= hl_w;
      b2_pp8 <= pp8_w[63:0];
      b2_p   <= b1_p;
      temp2  <= temp1;

      b3_qq <= $signed(b2_ll + {b2_hl[30:0], 33'b0});
      b3_c2 <= b2_pp8 >>> 19;
      b3_p  <= b2_p;
      temp3 <= temp2;

      b4_c1 <= pq_lo >>> 25;
      b4_c2 <= b3_c2;
      b4_p  <= b3_p;
      temp4 <= temp3;
    end
  end

  assign out_valid        = v[3];
  assign out_data.invalid = inv[3];
  assign out_data.temp    = temp4;
  assign out_data.press   = inv[3] ? 32'd0 : press;

endmodule
`default_nettype wire

/* hdl/barometric_sensor_compensation.sv */
// Barometric sensor compensation, 64-bit integer scheme.
// sample: one raw 20-bit temperature and one raw 20-bit pressure per item,
//   taken when valid and ready are both high.
// result: temperature in 0.01 degC, pressure in Pa as unsigned Q24.8 and an
//   invalid flag raised (pressure 0) when the divisor term is zero.
// Trim words (cfg_we / cfg_index / cfg_data) reset to zero; the user must
//   write them only while no item is in flight: the block does not enforce it.
// Throughput: one item per cycle unless the pipeline is frozen (see below).
// From acceptance to the result being shown an item passes 10 front stages
//   (temperature and divisor terms), 64 divider cells with one quotient bit
//   each, 4 correction stages and the output register.
// A stalled receiver holds the output register; the next item lands in a
//   skid register and the pipeline then freezes with sample.ready low until
//   the result is taken.
// Reset (synchronous, active high) empties the pipeline and clears the trims.
`default_nettype none
module barometric_sensor_compensation (
  input  wire logic        clk,
  input  wire logic        rst,
  bsc_in_if.sink           sample,
  bsc_out_if.source        result,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import bsc_pkg::*;

  logic [47:0] temp_trim;
  logic [63:0] press_trim_low;
  logic [63:0] press_trim_mid;
  logic [15:0] press_trim_high;
  trim_t       trim;

  logic        en;
  logic        cv [0:DIV_BITS];
  div_t        cd [0:DIV_BITS];
  logic        back_valid;
  res_t        back_data;
  logic        out_valid, skid_valid;
  res_t        out_data, skid_data;
  logic        out_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_trim       <= '0;
      press_trim_low  <= '0;
      press_trim_mid  <= '0;
      press_trim_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_TRIM:  temp_trim       <= cfg_data[47:0];
        REG_PRESS_LOW:  press_trim_low  <= cfg_data;
        REG_PRESS_MID:  press_trim_mid  <= cfg_data;
        REG_PRESS_HIGH: press_trim_high <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    trim.t1 = temp_trim[15:0];
    trim.t2 = temp_trim[31:16];
    trim.t3 = temp_trim[47:32];
    trim.p1 = press_trim_low[15:0];
    trim.p2 = press_trim_low[31:16];
    trim.p3 = press_trim_low[47:32];
    trim.p4 = press_trim_low[63:48];
    trim.p5 = press_trim_mid[15:0];
    trim.p6 = press_trim_mid[31:16];
    trim.p7 = press_trim_mid[47:32];
    trim.p8 = press_trim_mid[63:48];
    trim.p9 = press_trim_high;
  end

  // advance the whole pipeline while the skid register is free
  assign en           = ~skid_valid;
  assign sample.ready = en;

  bsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sample.valid),
    .raw_t     (sample.raw_temperature),
    .raw_p     (sample.raw_pressure),
    .trim      (trim),
    .out_valid (cv[0]),
    .out_data  (cd[0])
  );

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
    bsc_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cv[i]),
      .in_data   (cd[i]),
      .out_valid (cv[i+1]),
      .out_data  (cd[i+1])
    );
  end

  bsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cv[DIV_BITS]),
    .in_data   (cd[DIV_BITS]),
    .trim      (trim),
    .out_valid (back_valid),
    .out_data  (back_data)
  );

  assign out_fire = out_valid & result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (~out_valid | out_fire) begin
      out_valid <= back_valid;
    end else if (back_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (~out_valid | out_fire) begin
      out_data <= back_data;
    end else begin
      skid_data <= back_data;
    end
  end

  assign result.valid             = out_valid;
  assign result.temperature_centi = out_data.temp;
  assign result.pressure_q24_8    = out_data.press;
  assign result.pressure_invalid  = out_data.invalid;

endmodule
`default_nettype wire

/* verif/bsc_test_if.sv */
`timescale 1ns / 100ps
// The block's own channel interfaces (bsc_in_if, bsc_out_if) are used directly;
// this file only carries the configuration write bundle.
interface bsc_cfg_port;
  logic        we;
  logic [1:0]  index;
  logic [63:0] data;
endinterface

/* verif/barometric_sensor_compensation_test.sv */
`timescale 1ns / 100ps
module barometric_sensor_compensation_test;
  import bsc_pkg::*;

  typedef struct packed {
    logic signed [31:0] temp;
    logic        [31:0] press;
    logic               invalid;
  } reading_t;

  localparam int LATENCY = 79;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bsc_in_if  sample ();
  bsc_out_if result ();
  bsc_cfg_port cfg ();

  barometric_sensor_compensation uut (
    .clk(clk), .rst(rst), .sample(sample.sink), .result(result.source),
    .cfg_we(cfg.we), .cfg_index(cfg.index), .cfg_data(cfg.data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [47:0] temp_trim;
  logic [63:0] press_low, press_mid;
  logic [15:0] press_high;
  reading_t expected_readings[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  function automatic logic signed [63:0] trim_word(input logic [63:0] w, input int sh);
    logic signed [15:0] v;
    v = w[sh +: 16];
    return 64'(v);
  endfunction

  function automatic logic [63:0] asr(input logic [63:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic reading_t compensate(input logic [19:0] adc_t, input logic [19:0] adc_p);
    logic [31:0] t1, t2, t3, d1, d2, v1, v2, sq, tfine, tc;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, q, c1, c2, an, ad, qq;
    reading_t r;
    t1 = {16'd0, temp_trim[15:0]};
    t2 = 32'(signed'(temp_trim[31:16]));
    t3 = 32'(signed'(temp_trim[47:32]));
    d1 = 32'(adc_t >> 3) - (t1 << 1);
    v1 = $signed(32'(d1 * t2)) >>> 11;
    d2 = 32'(adc_t >> 4) - t1;
    sq = $signed(32'(d2 * d2)) >>> 12;
    v2 = $signed(32'(sq * t3)) >>> 14;
    tfine = v1 + v2;
    tc = $signed(32'(tfine * 32'd5 + 32'd128)) >>> 8;
    p1 = {48'd0, press_low[15:0]};
    p2 = trim_word(press_low, 16);
    p3 = trim_word(press_low, 32);
    p4 = trim_word(press_low, 48);
    p5 = trim_word(press_mid, 0);
    p6 = trim_word(press_mid, 16);
    p7 = trim_word(press_mid, 32);
    p8 = trim_word(press_mid, 48);
    p9 = trim_word({48'd0, press_high}, 0);
    a = 64'(signed'(tfine)) - 64'd128000;
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    a = asr(a * a * p3, 8) + ((a * p2) << 12);
    a = asr(((64'd1 << 47) + a) * p1, 33);
    r.temp = tc;
    r.press = '0;
    r.invalid = 1'b0;
    if (a == 64'd0) begin
      r.invalid = 1'b1;
    end else begin
      p = 64'd1048576 - {44'd0, adc_p};
      p = ((p << 31) - b) * 64'd3125;
      an = p[63] ? -p : p;
      ad = a[63] ? -a : a;
      qq = an / ad;
      p = (p[63] != a[63]) ? -qq : qq;
      q = asr(p, 13);
      c1 = asr(p9 * q * q, 25);
      c2 = asr(p8 * p, 19);
      p = asr(p + c1 + c2, 8) + (p7 << 4);
      r.press = p[31:0];
    end
    return r;
  endfunction

  task automatic write_trim(input logic [1:0] idx, input logic [63:0] value);
    cfg.we <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    case (idx)
      REG_TEMP_TRIM:  temp_trim = value[47:0];
      REG_PRESS_LOW:  press_low = value;
      REG_PRESS_MID:  press_mid = value;
      REG_PRESS_HIGH: press_high = value[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    sample.valid <= 1'b0;
    wait (expected_readings.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic load_trims(input logic [47:0] tt, input logic [63:0] pl, input logic [63:0] pm,
                            input logic [15:0] ph);
    drain();
    write_trim(REG_TEMP_TRIM, {16'd0, tt});
    write_trim(REG_PRESS_LOW, pl);
    write_trim(REG_PRESS_MID, pm);
    write_trim(REG_PRESS_HIGH, {48'd0, ph});
    cfg.we <= 1'b0;
  endtask

  task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.raw_temperature <= rt;
    sample.raw_pressure <= rp;
    do @(posedge clk); while (!sample.ready);
    expected_readings.push_back(compensate(rt, rp));
  endtask

  always @(posedge clk) begin
    result.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && result.valid && result.ready) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = expected_readings.pop_front();
        if (result.temperature_centi !== want.temp || result.pressure_q24_8 !== want.press ||
            result.pressure_invalid !== want.invalid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected t=%0d p=%h inv=%b, got t=%0d p=%h inv=%b",
                     want.temp, want.press, want.invalid, result.temperature_centi,
                     result.pressure_q24_8, result.pressure_invalid);
        end
      end
    end
  end

  // end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((sample.valid && sample.ready) || (result.valid && result.ready) ||
        (!sample.valid && expected_readings.size() == 0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_zero_trims();
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h80000, 20'h5A5A5);
  endtask

  task automatic test_typical_trims();
    load_trims({16'hFC18, 16'h6A00, 16'd27504}, {16'd2855, 16'd140, 16'hD4BD, 16'd36477},
               {16'h0F8E, 16'hFFF9, 16'hFF8C, 16'h0C8A}, 16'd6000);
    send_reading(20'd519888, 20'd415148);
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'd0);
    send_reading(20'd0, 20'hFFFFF);
    send_reading(20'h55555, 20'hAAAAA);
  endtask

  task automatic test_extreme_trims();
    load_trims(48'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'd0, 20'd0);
    load_trims(48'h8000_8000_0000, 64'h8000_8000_8000_0001, 64'h8000_8000_8000_8000, 16'h8000);
    send_reading(20'hFFFFF, 20'd0);
    send_reading(20'd0, 20'hFFFFF);
    load_trims('1, '1, '1, '1);
    send_reading(20'h12345, 20'hFEDCB);
    send_reading(20'hFFFFF, 20'hFFFFF);
    // p1 zero forces the divisor term to zero
    load_trims({16'hFC18, 16'h6A00, 16'd27504}, 64'h1234_5678_9ABC_0000, '1, 16'h1234);
    send_reading(20'd519888, 20'd415148);
  endtask

  task automatic test_random_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      // mostly realistic trims with random content, occasionally full-range ones
      if (i % 50 == 0) begin
        if ($urandom_range(3) == 0)
          load_trims(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                     16'($urandom));
        else
          load_trims({16'(-$urandom_range(1500)), 16'(26000 + $urandom_range(2000)),
                      16'(27000 + $urandom_range(1500))},
                     {16'(8000 - $urandom_range(12000)), 16'(-3000 + $urandom_range(1000)),
                      16'(-11000 + $urandom_range(2000)), 16'(35000 + $urandom_range(2000))},
                     {16'($urandom_range(32767) - 16384), 16'(-$urandom_range(20)),
                      16'(-$urandom_range(300)), 16'($urandom_range(200))},
                     16'($urandom_range(8000)));
      end
      if ($urandom_range(4) == 0)
        send_reading(20'($urandom), 20'($urandom));
      else
        send_reading(20'(400000 + $urandom_range(250000)), 20'(250000 + $urandom_range(300000)));
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    sample.valid = 1'b0;
    sample.raw_temperature = '0;
    sample.raw_pressure = '0;
    result.ready = 1'b0;
    cfg.we = 1'b0;
    cfg.index = REG_TEMP_TRIM;
    cfg.data = '0;
    temp_trim = '0;
    press_low = '0;
    press_mid = '0;
    press_high = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_trims();
    test_typical_trims();
    test_extreme_trims();
    test_random_phase(320, 0, 0);
    test_random_phase(310, 50, 0);
    test_random_phase(310, 0, 50);
    test_random_phase(310, 19, 19);
    drain();
    if (mismatches == 0 && expected_readings.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
